// ----- rtl/bba_pkg.sv -----
// Package for the bitmap block allocator: shared types, codes and command structs.
// No dependencies.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned AddrW = 12;
  localparam int unsigned CntW  = 13;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAME    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture request
    logic scan_start;  // start segment scan from bit 0 (scan_map) or from target
    logic scan_map;    // scan segment 0 from bit 0
    logic scan_step;   // advance scan by one word
    logic rd_word;     // read word of bit under test (free / commit)
    logic commit;      // apply update and build result
    logic out_load;    // register result
  } bba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic word_valid;  // read data of issued word is available
  } bba_sts_t;

endpackage

// ----- rtl/bba_if.sv -----
// Valid/ready request channels of the bitmap block allocator.
// Depends on bba_pkg.
`timescale 1ns / 1ps
interface bba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [bba_pkg::AddrW-1:0] target;
  modport source (output valid, kind, target, input ready);
  modport sink   (input valid, kind, target, output ready);
endinterface

interface bba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::AddrW-1:0] address;
  logic                      grew;
  logic                      map_created;
  logic [bba_pkg::AddrW-1:0] map_location;
  logic [1:0]                status;
  logic [bba_pkg::CntW-1:0]  free_blocks;
  modport source (output valid, address, grew, map_created, map_location, status,
                  free_blocks, input ready);
  modport sink   (input valid, address, grew, map_created, map_location, status,
                  free_blocks, output ready);
endinterface

// ----- rtl/bba_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/bba_ctrl.sv -----
// Controller state machine of the bitmap block allocator.
// Depends on bba_pkg.
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic              need_map_i,
  input  logic              found_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bba_pkg::bba_sts_t sts_i,
  output bba_pkg::bba_cmd_t cmd_o
);
  import bba_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_MSCAN = 7'b0000100,
    S_RD    = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_COMM  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   kind_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (kind_i == KIND_FREE) begin
            state_d = S_RD;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          if (!found_i && need_map_i) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_map   = 1'b1;
            state_d = S_MSCAN;
          end else begin
            state_d = S_COMM;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_MSCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_COMM;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_RD: begin
        cmd_o.rd_word = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.word_valid) begin
          state_d = S_COMM;
        end
      end
      S_COMM: begin
        cmd_o.commit = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      kind_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cmd_o.load) kind_q <= kind_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // A free request never runs a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> kind_q == KIND_ALLOC)
    else $error("scan during free");
  // Result register loads only while it is empty or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");
  // Commit is always followed by the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> state_q == S_OUT)
    else $error("commit not followed by output");
endmodule

// ----- rtl/bba_dp.sv -----
// Datapath of the bitmap block allocator: bitmap RAM, segment maps, counters, scan.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
module bba_dp #(
  parameter int unsigned MaxBlocks   = 4096,
  parameter int unsigned SegmentBits = 1024,
  parameter int unsigned WordBits    = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bba_pkg::bba_cmd_t          cmd_i,
  output bba_pkg::bba_sts_t          sts_o,
  input  logic                       kind_i,
  input  logic [bba_pkg::AddrW-1:0]  target_i,
  output logic                       need_map_o,
  output logic                       found_o,
  output logic                       busy_o,
  output logic [bba_pkg::AddrW-1:0]  address_o,
  output logic                       grew_o,
  output logic                       map_created_o,
  output logic [bba_pkg::AddrW-1:0]  map_location_o,
  output logic [1:0]                 status_o,
  output logic [bba_pkg::CntW-1:0]   free_blocks_o
);
  import bba_pkg::*;

  localparam int unsigned NumWords = (MaxBlocks + WordBits - 1) / WordBits;
  localparam int unsigned NumSegs  = (MaxBlocks + SegmentBits - 1) / SegmentBits;
  localparam int unsigned WIdxW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned BitW     = $clog2(WordBits);
  localparam int unsigned SegW     = (NumSegs > 1) ? $clog2(NumSegs) : 1;
  localparam int unsigned SegShift = $clog2(SegmentBits);
  localparam int unsigned BW       = $clog2(MaxBlocks) + 1; // block numbers incl. MaxBlocks

  // Bitmap RAM. Words never written read as zero through valid bits; blocks 0,1
  // live in word 0 which is forced at reset via valid bit and reset pattern.
  logic                 we;
  logic [WIdxW-1:0]     waddr, raddr;
  logic [WordBits-1:0]  wdata, rdata;
  logic [NumWords-1:0]  wvalid_q;
  logic                 rvalid_q;

  bba_ram #(.Width(WordBits), .Depth(NumWords)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [WordBits-1:0] word_rst;
  assign word_rst = WordBits'(3);

  logic [WIdxW-1:0]    rd_idx_q;
  logic [WordBits-1:0] word;
  assign word = wvalid_q[rd_idx_q] ? rdata
              : ((rd_idx_q == '0) ? word_rst : '0);

  logic [AddrW-1:0]   seg_map_q [NumSegs];
  logic [BW-1:0]      block_count_q;
  logic [CntW-1:0]    free_count_q;
  logic               kind_q;
  logic [AddrW-1:0]   target_q;

  // Scan state.
  logic [BW-1:0]      pos_q;      // current bit position
  logic [BW-1:0]      lim_q;      // exclusive limit
  logic               scanning_q; // a word read is in flight
  logic               done_q;
  logic               hit_q;
  logic [BW-1:0]      hit_pos_q;
  logic               first_hit_q;
  logic [BW-1:0]      first_pos_q;
  logic               map_phase_q;

  // Scan setup from a start bit.
  logic [BW-1:0]      start_b;
  logic [SegW-1:0]    start_seg;
  logic [BW-1:0]      seg_end;
  logic               seg_ok;
  assign start_b   = cmd_i.scan_map ? '0 : BW'(target_i);
  assign start_seg = SegW'(start_b >> SegShift);
  assign seg_end   = BW'((({1'b0, start_b} >> SegShift) + 1) << SegShift);
  assign seg_ok    = ((start_b >> SegShift) < NumSegs) && (seg_map_q[start_seg] != '0);

  // Mask of bits in the word at pos_q that lie within [pos_q, lim_q).
  logic [WordBits-1:0] mask, cand;
  logic [BW-1:0]       wbase;
  logic                cand_any;
  logic [BitW-1:0]     cand_bit;
  always_comb begin
    wbase = {pos_q[BW-1:BitW], {BitW{1'b0}}};
    for (int i = 0; i < WordBits; i++) begin
      mask[i] = (BW'(wbase + BW'(i)) >= pos_q) && (BW'(wbase + BW'(i)) < lim_q);
    end
    cand     = ~word & mask;
    cand_any = |cand;
    cand_bit = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (cand[i]) cand_bit = BitW'(i);
    end
  end

  logic [BW-1:0] next_pos;
  assign next_pos = wbase + BW'(WordBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q  <= 1'b0;
      done_q      <= 1'b0;
      rvalid_q    <= 1'b0;
      pos_q       <= '0;
      lim_q       <= '0;
      hit_q       <= 1'b0;
      hit_pos_q   <= '0;
      map_phase_q <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      rvalid_q <= 1'b0;
      if (cmd_i.scan_start) begin
        done_q     <= 1'b0;
        scanning_q <= 1'b0;
        pos_q      <= start_b;
        lim_q      <= (seg_end > block_count_q) ? block_count_q : seg_end;
        hit_q      <= 1'b0;
        map_phase_q <= cmd_i.scan_map;
        if (!seg_ok || start_b >= block_count_q
            || start_b >= ((seg_end > block_count_q) ? block_count_q : seg_end)) begin
          done_q <= 1'b1;
        end
      end else if (cmd_i.scan_step) begin
        if (!scanning_q) begin
          scanning_q <= 1'b1;
          rvalid_q   <= 1'b1;
          rd_idx_q   <= WIdxW'(pos_q >> BitW);
        end else if (rvalid_q) begin
          scanning_q <= 1'b0;
          if (cand_any) begin
            hit_q     <= 1'b1;
            hit_pos_q <= wbase | BW'(cand_bit);
            done_q    <= 1'b1;
          end else if (next_pos >= lim_q) begin
            done_q <= 1'b1;
          end else begin
            pos_q <= next_pos;
          end
        end
      end
      if (cmd_i.rd_word) begin
        rvalid_q <= 1'b1;
        rd_idx_q <= WIdxW'(target_q >> BitW);
      end
    end
  end

  // First-phase result is kept while the map scan runs.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_map) begin
      first_hit_q <= hit_q && hit_pos_q != '0;
      first_pos_q <= hit_pos_q;
    end
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      target_q <= target_i;
    end
  end

  logic found_now;
  assign found_now = hit_q && hit_pos_q != '0;
  assign found_o   = found_now;

  logic [SegW-1:0] grow_seg;
  assign grow_seg   = SegW'(block_count_q >> SegShift);
  assign need_map_o = (kind_q == KIND_ALLOC) && (block_count_q < MaxBlocks)
                   && ((block_count_q >> SegShift) < NumSegs)
                   && (seg_map_q[grow_seg] == '0);

  assign sts_o.scan_done  = done_q;
  assign sts_o.word_valid = rvalid_q;

  // Free needs the target bit; it sits in the word just read.
  logic [BitW-1:0] tbit;
  assign tbit = BitW'(target_q);

  // Commit: result and update.
  logic [AddrW-1:0] r_addr, r_mloc;
  logic             r_grew, r_mc;
  status_e          r_st;
  logic             upd_a, upd_m, upd_seg, upd_free, dec1, dec2, inc;
  logic [BW-1:0]    a_blk, m_blk, new_count;
  logic             ok_grow, m_reused, first_found;
  always_comb begin
    r_addr = '0; r_mloc = '0; r_grew = 1'b0; r_mc = 1'b0; r_st = ST_OK;
    upd_a = 1'b0; upd_m = 1'b0; upd_seg = 1'b0; upd_free = 1'b0;
    dec1 = 1'b0; dec2 = 1'b0; inc = 1'b0;
    a_blk = '0; m_blk = '0; new_count = block_count_q;
    ok_grow = 1'b1; m_reused = 1'b0;
    first_found = map_phase_q ? first_hit_q : found_now;
    if (kind_q == KIND_FREE) begin
      r_addr = target_q;
      if (target_q == '0 || BW'(target_q) >= block_count_q) begin
        r_st = ST_RANGE;
      end else if (!word[tbit]) begin
        r_st = ST_SAME;
      end else begin
        upd_free = 1'b1;
        inc = 1'b1;
      end
    end else if (first_found) begin
      a_blk = map_phase_q ? first_pos_q : hit_pos_q;
      r_addr = AddrW'(a_blk);
      upd_a = 1'b1;
      dec1 = 1'b1;
    end else if (block_count_q >= MaxBlocks) begin
      r_st = ST_FULL;
    end else begin
      a_blk = block_count_q;
      new_count = block_count_q + 1'b1;
      if (need_map_o) begin
        if (found_now) begin
          m_blk = hit_pos_q;
          m_reused = 1'b1;
        end else if (new_count >= MaxBlocks) begin
          ok_grow = 1'b0;
        end else begin
          m_blk = new_count;
          new_count = new_count + 1'b1;
        end
      end
      if (!ok_grow) begin
        r_st = ST_FULL;
        new_count = block_count_q;
      end else begin
        upd_a = 1'b1;
        r_addr = AddrW'(a_blk);
        r_grew = 1'b1;
        if (need_map_o) begin
          upd_m = 1'b1; upd_seg = 1'b1; r_mc = 1'b1;
          r_mloc = AddrW'(m_blk);
          dec2 = m_reused;
        end
      end
    end
  end

  // Bit writes run as read-modify-write over a short sequence after commit.
  // Pending writes: at most two (map block and allocated or freed block).
  logic          wr_pend_q [2];
  logic [BW-1:0] wr_blk_q  [2];
  logic          wr_set_q  [2];
  logic [1:0]    wph_q;   // 0 issue read, 1 wait, 2 write
  logic          wsel_q;
  logic [CntW-1:0] fc;
  logic          busy_w;

  always_comb begin
    fc = free_count_q;
    if (inc && fc < CntW'(MaxBlocks)) fc = fc + 1'b1;
    if (dec1 && fc != '0) fc = fc - 1'b1;
    if (dec2 && fc != '0) fc = fc - 1'b1;
  end

  // The write engine owns the RAM port from commit until its pending writes land;
  // new requests are held off meanwhile, so no scan competes for it.
  logic [WIdxW-1:0]    wi;
  logic [BitW-1:0]     wb;
  logic [WordBits-1:0] cur;
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    wi    = '0;
    wb    = '0;
    cur   = '0;
    if (wph_q == 2'd2) begin
      wi  = WIdxW'(wr_blk_q[wsel_q] >> BitW);
      wb  = BitW'(wr_blk_q[wsel_q]);
      cur = wvalid_q[wi] ? rdata : ((wi == '0) ? word_rst : '0);
      we  = 1'b1;
      waddr = wi;
      wdata = cur;
      wdata[wb] = wr_set_q[wsel_q];
    end
  end

  logic [WIdxW-1:0] wr_raddr;
  assign wr_raddr = WIdxW'(wr_blk_q[wsel_q] >> BitW);

  assign busy_w = wr_pend_q[0] | wr_pend_q[1];
  assign busy_o = busy_w;

  // Hold the read address on the word in use: pending write, free target or scan.
  assign raddr = busy_w ? wr_raddr
               : (kind_q == KIND_FREE) ? WIdxW'(target_q >> BitW)
               : WIdxW'(pos_q >> BitW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BW'(2);
      free_count_q  <= '0;
      wvalid_q      <= '0;
      for (int s = 0; s < NumSegs; s++) seg_map_q[s] <= (s == 0) ? AddrW'(1) : '0;
      wr_pend_q[0]  <= 1'b0;
      wr_pend_q[1]  <= 1'b0;
      wr_blk_q[0]   <= '0;
      wr_blk_q[1]   <= '0;
      wr_set_q[0]   <= 1'b0;
      wr_set_q[1]   <= 1'b0;
      wph_q         <= '0;
      wsel_q        <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        block_count_q <= new_count;
        free_count_q  <= fc;
        if (upd_seg) seg_map_q[grow_seg] <= AddrW'(m_blk);
        wr_pend_q[0] <= upd_m;
        wr_blk_q[0]  <= m_blk;
        wr_set_q[0]  <= 1'b1;
        wr_pend_q[1] <= upd_a | upd_free;
        wr_blk_q[1]  <= upd_free ? BW'(target_q) : a_blk;
        wr_set_q[1]  <= !upd_free;
        wsel_q       <= !upd_m;
        wph_q        <= '0;
      end else if (wr_pend_q[wsel_q]) begin
        case (wph_q)
          2'd0: wph_q <= 2'd1;
          2'd1: wph_q <= 2'd2;
          default: begin
            wph_q <= '0;
            wvalid_q[wi] <= 1'b1;
            wr_pend_q[wsel_q] <= 1'b0;
            wsel_q <= 1'b1;
          end
        endcase
      end
    end
  end

  logic [AddrW-1:0] r_addr_q, r_mloc_q;
  logic             r_grew_q, r_mc_q;
  logic [1:0]       r_st_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      r_addr_q <= r_addr; r_mloc_q <= r_mloc; r_grew_q <= r_grew;
      r_mc_q <= r_mc; r_st_q <= r_st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      address_o      <= r_addr_q;
      grew_o         <= r_grew_q;
      map_created_o  <= r_mc_q;
      map_location_o <= r_mloc_q;
      status_o       <= r_st_q;
      free_blocks_o  <= free_count_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> block_count_q <= BW'(MaxBlocks))
    else $error("block count past capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= CntW'(MaxBlocks))
    else $error("free count past capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !busy_w)
    else $error("commit with bitmap writes pending");
endmodule

// ----- rtl/bitmap_block_allocator_unit.sv -----
// Top level of the bitmap block allocator: controller plus datapath.
// Depends on bba_pkg, bba_if, bba_ram, bba_ctrl and bba_dp.
`timescale 1ns / 1ps
// Usage:
//   req (sink): kind selects allocate (0) or free (1); target is the search
//   hint or the block to release. rsp (source): address, grew, map_created,
//   map_location, status and the free count after the request.
//   One request is in work at a time. Allocate scans from the hint to the
//   end of its segment one bitmap word at a time, each word read through the
//   registered RAM; the scan covers at most SegmentBits/WordBits words, and
//   segment 0 is searched too when no block was found and a map is needed.
//   A free reads the word of its target block, then commits. Commit starts
//   up to two bitmap read-modify-writes; the next request is accepted only
//   once they finish.
//   Reset marks blocks 0 and 1 used, segment 0 mapped at block 1, two blocks
//   in the store and no free blocks; the bitmap RAM needs no clearing pass
//   since per-word valid bits stand in for its reset value.
//   A stalled rsp holds its result; the next request can be accepted and
//   worked while it waits, and its result is held until rsp drains.
module bitmap_block_allocator_unit #(
  parameter int unsigned MaxBlocks   = 4096,
  parameter int unsigned SegmentBits = 1024,
  parameter int unsigned WordBits    = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  bba_sts_t sts;
  logic     need_map, found, idle_ready;
  logic     busy_w;

  bba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid & ~busy_w),
    .in_ready_o (idle_ready),
    .kind_i     (req.kind),
    .need_map_i (need_map),
    .found_i    (found),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold off new requests while bitmap writes of the last one drain.
  assign req.ready = idle_ready & ~busy_w;

  bba_dp #(
    .MaxBlocks(MaxBlocks), .SegmentBits(SegmentBits), .WordBits(WordBits)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (req.kind),
    .target_i      (req.target),
    .need_map_o    (need_map),
    .found_o       (found),
    .busy_o        (busy_w),
    .address_o     (rsp.address),
    .grew_o        (rsp.grew),
    .map_created_o (rsp.map_created),
    .map_location_o(rsp.map_location),
    .status_o      (rsp.status),
    .free_blocks_o (rsp.free_blocks)
  );
endmodule
